/* sv/vrbu_pkg.sv */
package vrbu_pkg;

  // Fixed widths of the stream and of the result fields.
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 16;

  // Default field widths and queue depth.
  localparam int VALUE_WIDTH_DEF     = 8;
  localparam int RUNLENGTH_WIDTH_DEF = 6;
  localparam int FIFO_DEPTH_DEF      = 4;

  // A run length field with this value closes a block.
  localparam int BLOCK_END_CODE = 63;

  // At most three fields of one byte are kept in an entry.
  localparam int MAX_RES = 3;

  // Everything one byte produced, as handed from the front to the back.
  typedef struct packed {
    logic [1:0]                      count;
    logic [MAX_RES-1:0][FIELD_W-1:0] data;
    logic [MAX_RES-1:0]              kind;
    logic [MAX_RES-1:0]              blk_end;
  } vrbu_entry_t;

endpackage

/* sv/vrbu_front.sv */
module vrbu_front import vrbu_pkg::*; #(
  parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF,
  parameter int RUNLENGTH_WIDTH = RUNLENGTH_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [BYTE_W-1:0] packed_byte_i,
  input  logic              fifo_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output vrbu_entry_t       entry_o
);

  localparam int AccW  = (VALUE_WIDTH > RUNLENGTH_WIDTH) ? VALUE_WIDTH : RUNLENGTH_WIDTH;
  localparam int HeldW = $clog2(AccW + 1);

  logic [AccW-1:0]  acc_q, acc_d;
  logic [HeldW-1:0] held_q, held_d;
  logic             kind_q, kind_d;
  logic [1:0]       cnt_v;
  logic             stop_v;
  logic             end_v;
  logic             accept;

  // A byte is taken whenever the queue has room for its results.
  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;

  // Walk the eight bits of the byte, most significant first, closing fields.
  always_comb begin
    acc_d   = acc_q;
    held_d  = held_q;
    kind_d  = kind_q;
    cnt_v   = '0;
    stop_v  = 1'b0;
    end_v   = 1'b0;
    entry_o = '0;
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      if (!stop_v) begin
        acc_d  = {acc_d[AccW-2:0], packed_byte_i[b]};
        held_d = held_d + HeldW'(1);
        if (held_d == (kind_d ? HeldW'(RUNLENGTH_WIDTH) : HeldW'(VALUE_WIDTH))) begin
          end_v = kind_d && (acc_d == AccW'(BLOCK_END_CODE));
          if (cnt_v != 2'(MAX_RES)) begin
            entry_o.data[cnt_v]    = FIELD_W'(acc_d);
            entry_o.kind[cnt_v]    = kind_d;
            entry_o.blk_end[cnt_v] = end_v;
            cnt_v = cnt_v + 2'd1;
          end
          acc_d  = '0;
          held_d = '0;
          if (end_v) begin
            // Rest of the byte is padding; next block opens with a value.
            kind_d = 1'b0;
            stop_v = 1'b1;
          end else begin
            kind_d = !kind_d;
          end
        end
      end
    end
    entry_o.count = cnt_v;
  end

  // Bytes that close no field only advance the accumulator.
  assign push_o = accept && (cnt_v != 2'd0);

  // Accumulator, bit count and kind of the field in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      held_q <= '0;
      kind_q <= 1'b0;
    end else if (accept) begin
      acc_q  <= acc_d;
      held_q <= held_d;
      kind_q <= kind_d;
    end
  end

endmodule

/* sv/vrbu_fifo.sv */
module vrbu_fifo import vrbu_pkg::*; #(
  parameter int Depth = FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  vrbu_entry_t entry_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        empty_o,
  output vrbu_entry_t head_o
);

  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  vrbu_entry_t      mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i)
    else $error("vrbu_fifo: push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("vrbu_fifo: pop from an empty queue");
`endif

endmodule

/* sv/vrbu_back.sv */
module vrbu_back import vrbu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fifo_empty_i,
  input  vrbu_entry_t        head_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [FIELD_W-1:0] field_data_o,
  output logic               field_kind_o,
  output logic               block_end_o,
  output logic               last_of_byte_o
);

  logic [1:0]         idx_q;
  logic               valid_q;
  logic [FIELD_W-1:0] data_q;
  logic               kind_q, end_q, last_q;
  logic               load;
  logic               last;

  // The output register takes a new result when it is empty or being taken.
  assign load  = !fifo_empty_i && (!valid_q || !out_stall_i);
  assign last  = (idx_q == head_i.count - 2'd1);
  assign pop_o = load && last;

  // Result index within the head entry and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= head_i.data[idx_q];
      kind_q <= head_i.kind[idx_q];
      end_q  <= head_i.blk_end[idx_q];
      last_q <= last;
    end
  end

  assign out_valid_o    = valid_q;
  assign field_data_o   = data_q;
  assign field_kind_o   = kind_q;
  assign block_end_o    = end_q;
  assign last_of_byte_o = last_q;

`ifndef SYNTHESIS
  a_idx_in_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fifo_empty_i |-> (head_i.count != 2'd0) && (idx_q < head_i.count))
    else $error("vrbu_back: result index outside the head entry");
`endif

endmodule

/* sv/value_runlength_bit_unpacker.sv */
// An accepted byte that closes a field is written into the queue, and its first field then
// enters the output register; its other fields follow one per cycle while out_stall_i is low.
// Throughput: one byte per cycle in while the queue has room, one field per cycle out unless
// stalled; a byte that closes k fields takes k transfers; a four-entry queue absorbs bursts.
// Reset: asynchronous, active low; clears the accumulator, bit count, field kind,
// queue pointers and output valid; the first field after reset is a value field.
module value_runlength_bit_unpacker import vrbu_pkg::*; #(
  parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF,
  parameter int RUNLENGTH_WIDTH = RUNLENGTH_WIDTH_DEF,
  parameter int FIFO_DEPTH      = FIFO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [BYTE_W-1:0]  packed_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FIELD_W-1:0] field_data_o,
  output logic               field_kind_o,
  output logic               block_end_o,
  output logic               last_of_byte_o
);

  logic        fifo_full, fifo_empty, push, pop;
  vrbu_entry_t entry, head;

  // Front: cuts each byte into fields and tracks the field in progress.
  vrbu_front #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .RUNLENGTH_WIDTH(RUNLENGTH_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .packed_byte_i(packed_byte_i),
    .fifo_full_i  (fifo_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .entry_o      (entry)
  );

  // Queue of per-byte results between the two sides.
  vrbu_fifo #(
    .Depth(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .full_o (fifo_full),
    .empty_o(fifo_empty),
    .head_o (head)
  );

  // Back: hands out the fields one transfer at a time.
  vrbu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_empty_i  (fifo_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .field_data_o  (field_data_o),
    .field_kind_o  (field_kind_o),
    .block_end_o   (block_end_o),
    .last_of_byte_o(last_of_byte_o)
  );

`ifndef SYNTHESIS
  a_end_is_runlength: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_end_o |-> field_kind_o &&
      (field_data_o == FIELD_W'(BLOCK_END_CODE)) && last_of_byte_o)
    else $error("block end flagged on a field that cannot close a block");

  a_end_detected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o && (field_data_o == FIELD_W'(BLOCK_END_CODE))
      |-> block_end_o)
    else $error("block end code passed without a block end flag");
`endif

endmodule
